// File: rtl/selective_repeat_receiver_window_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SRRW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srrw assertion failed");

// next-cycle implication, disabled while reset is low
`define SRRW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srrw assertion failed");

`endif

// File: rtl/srrw_pkg.sv
// ----------------------------------------------------------------------------
// srrw_pkg
// shared constants, codes and types of the selective-repeat receiver window
// ----------------------------------------------------------------------------
package srrw_pkg;

    localparam int WINDOW_SLOTS = 5;
    localparam int PAYLOAD_BITS = 32;

    // stored payload bits: the payload port carries 32 bits
    localparam int STORE_BITS = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int SLOT_W     = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    localparam logic [1:0] ACT_FRAME_LOST = 2'd1;
    localparam logic [1:0] ACT_ACK_LOST   = 2'd2;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef enum logic [2:0] {
        V_NEW_STORED = 3'd0,
        V_DUPLICATE  = 3'd1,
        V_ACK_LOST   = 3'd2,
        V_FRAME_LOST = 3'd3,
        V_OLD_REACK  = 3'd4,
        V_BEYOND     = 3'd5
    } t_verdict;

    typedef enum logic [1:0] {
        S_IDLE,
        S_VERDICT,
        S_DELIVER
    } t_state;

    // one access to the slot store
    typedef struct packed {
        logic                  we;
        logic [SLOT_W-1:0]     waddr;
        logic [STORE_BITS-1:0] wdata;
        logic [SLOT_W-1:0]     raddr;
    } t_store_cmd;

endpackage

// File: rtl/srrw_slot_store.sv
// ----------------------------------------------------------------------------
// srrw_slot_store
// payload memory of the window slots, one write and one registered read
// ----------------------------------------------------------------------------
module srrw_slot_store
    import srrw_pkg::*;
(
    input  logic                  i_clk,
    input  t_store_cmd            i_cmd,
    output logic [STORE_BITS-1:0] o_rdata
);

    logic [STORE_BITS-1:0] mem [WINDOW_SLOTS];
    logic [STORE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.waddr] <= i_cmd.wdata;
        end
    end

    // write-to-read forwarding on the same entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.we && (i_cmd.waddr == i_cmd.raddr)) begin
            r_rdata <= i_cmd.wdata;
        end else begin
            r_rdata <= mem[i_cmd.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/selective_repeat_receiver_window.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_window
// selective-repeat receiver: classifies frames, buffers in-window payloads and
// hands out frames in order as the window slides
// ----------------------------------------------------------------------------
//  channel  | handshake              | beat
//  ---------+------------------------+------------------------------------
//  frame in | start & ~busy          | i_frame_seq, i_payload, i_action
//  result   | o_strobe, one cycle    | o_kind, o_verdict, o_ack_*, o_delivered_*, o_last
//
//  an accepted frame gives 1 + n beats, n = frames slid out (0 to window size):
//  a verdict cycle, then one cycle per delivered frame from the slot store read port
//  busy is high from the edge after acceptance through the final beat's cycle, so
//  the next frame is taken only after the final beat of the last one
//  reset is synchronous, active low; the slot store needs no clearing pass
//  results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module selective_repeat_receiver_window
    import srrw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_frame_seq,
    input  logic [31:0] i_payload,
    input  logic [1:0]  i_action,
    output logic        o_strobe,
    output logic        o_kind,
    output logic [2:0]  o_verdict,
    output logic        o_ack_valid,
    output logic [31:0] o_ack_seq,
    output logic [31:0] o_delivered_seq,
    output logic [31:0] o_delivered_data,
    output logic        o_last
);

    localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W+1)'(WINDOW_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_SLOTS - 1);

    // control state
    t_state                  r_state, n_state;
    logic [31:0]             r_base;
    logic [SLOT_W-1:0]       r_head;
    logic [WINDOW_SLOTS-1:0] r_full;

    // captured frame
    logic [31:0]             r_seq;
    logic [STORE_BITS-1:0]   r_payload;
    logic [1:0]              r_action;

    // verdict datapath
    logic [31:0]             diff;
    logic                    is_old;
    logic                    in_win;
    logic [SLOT_W-1:0]       pos;
    logic [SLOT_W:0]         phys_sum;
    logic [SLOT_W-1:0]       phys;
    logic                    do_store;
    logic                    slide;
    logic                    acked;
    t_verdict                verdict;

    // delivery datapath
    logic [SLOT_W-1:0]       head_nxt;
    logic                    more;

    t_store_cmd              store_cmd;
    logic [STORE_BITS-1:0]   rdata;

    // window classification, exact unsigned compares with no wrap
    assign diff     = r_seq - r_base;
    assign is_old   = r_seq < r_base;
    assign in_win   = !is_old && (diff < 32'(WINDOW_SLOTS));
    assign pos      = diff[SLOT_W-1:0];
    // slot index in the circular store
    assign phys_sum = {1'b0, r_head} + {1'b0, pos};
    assign phys     = (phys_sum >= SLOTS_EXT) ? SLOT_W'(phys_sum - SLOTS_EXT)
                                              : phys_sum[SLOT_W-1:0];

    // frame lost stores nothing, ack lost always overwrites, normal skips full slots
    assign do_store = in_win && (r_action != ACT_FRAME_LOST) &&
                      ((r_action == ACT_ACK_LOST) || !r_full[phys]);
    // head slot is empty between frames, so a slide starts only on a store at the front
    assign slide    = do_store && (pos == '0);

    always_comb begin
        verdict = V_BEYOND;
        acked   = 1'b0;
        if (in_win) begin
            if (r_action == ACT_FRAME_LOST) begin
                verdict = V_FRAME_LOST;
            end else if (r_action == ACT_ACK_LOST) begin
                verdict = V_ACK_LOST;
            end else begin
                verdict = r_full[phys] ? V_DUPLICATE : V_NEW_STORED;
                acked   = 1'b1;
            end
        end else if (is_old) begin
            verdict = V_OLD_REACK;
            acked   = 1'b1;
        end
    end

    // next slot at the front, and whether it is still full after this beat
    assign head_nxt = (r_head == LAST_SLOT) ? '0 : r_head + SLOT_W'(1);
    assign more     = r_full[head_nxt] && (head_nxt != r_head);

    // slot store access: write on a store, read the front slot ahead of delivery
    always_comb begin
        store_cmd.we    = (r_state == S_VERDICT) && do_store;
        store_cmd.waddr = phys;
        store_cmd.wdata = r_payload;
        store_cmd.raddr = (r_state == S_DELIVER) ? head_nxt : r_head;
    end

    srrw_slot_store u_store (
        .i_clk   (i_clk),
        .i_cmd   (store_cmd),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_VERDICT;
                end
            end
            S_VERDICT: begin
                n_state = slide ? S_DELIVER : S_IDLE;
            end
            S_DELIVER: begin
                n_state = more ? S_DELIVER : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result beat
    always_comb begin
        busy             = 1'b1;
        o_strobe         = 1'b0;
        o_kind           = KIND_VERDICT;
        o_verdict        = 3'd0;
        o_ack_valid      = 1'b0;
        o_ack_seq        = 32'd0;
        o_delivered_seq  = 32'd0;
        o_delivered_data = 32'd0;
        o_last           = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_VERDICT: begin
                o_strobe    = 1'b1;
                o_verdict   = verdict;
                o_ack_valid = acked;
                o_ack_seq   = acked ? r_seq : 32'd0;
                o_last      = !slide;
            end
            S_DELIVER: begin
                o_strobe         = 1'b1;
                o_kind           = KIND_DELIVER;
                o_delivered_seq  = r_base;
                o_delivered_data = 32'(rdata);
                o_last           = !more;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= 32'd0;
            r_head  <= '0;
            r_full  <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_VERDICT) && do_store) begin
                r_full[phys] <= 1'b1;
            end
            if (r_state == S_DELIVER) begin
                r_full[r_head] <= 1'b0;
                r_head         <= head_nxt;
                r_base         <= r_base + 32'd1;
            end
        end
    end

    // frame capture
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_seq     <= i_frame_seq;
            r_payload <= i_payload[STORE_BITS-1:0];
            r_action  <= i_action;
        end
    end

endmodule

// File: rtl/srrw_checker.sv
// ----------------------------------------------------------------------------
// srrw_checker
// port-level checks of the receiver window, bound to the top level
// ----------------------------------------------------------------------------
`include "selective_repeat_receiver_window_macros.svh"

module srrw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic        o_kind,
    input logic [2:0]  o_verdict,
    input logic        o_ack_valid,
    input logic [31:0] o_ack_seq,
    input logic        o_last
);

    // every accepted frame opens with a verdict beat
    `SRRW_ASSERT_NXT(a_verdict_first, i_clk, i_rst_n, start && !busy, o_strobe && !o_kind)
    // a beat that is not the final one is followed by a delivered frame
    `SRRW_ASSERT_NXT(a_chain, i_clk, i_rst_n, o_strobe && !o_last, o_strobe && o_kind)
    // after the final beat the block is free again
    `SRRW_ASSERT_NXT(a_free_after_last, i_clk, i_rst_n, o_strobe && o_last, !busy)
    // delivered beats carry no verdict or ack
    `SRRW_ASSERT_IMP(a_deliver_clean, i_clk, i_rst_n, o_strobe && o_kind,
                     o_verdict == 3'd0 && !o_ack_valid && o_ack_seq == 32'd0)

endmodule

bind selective_repeat_receiver_window srrw_checker u_srrw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_kind      (o_kind),
    .o_verdict   (o_verdict),
    .o_ack_valid (o_ack_valid),
    .o_ack_seq   (o_ack_seq),
    .o_last      (o_last)
);
